// ===== src/ssc_pkg.sv =====
// Shared types and constants for the substring search and count block.
// No dependencies; every other file in src/ refers to it by scoped names.
`default_nettype none

package ssc_pkg;

    // Field and register widths, fixed by the interface definition
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PHRASE_W    = 64;
    localparam int unsigned LEN_W       = 4;
    localparam int unsigned SEL_W       = 3;
    localparam int unsigned INDEX_W     = 16;
    localparam int unsigned COUNT_W     = 17;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = PHRASE_W;

    // Defaults for the top-level parameters
    localparam int unsigned MAX_PHRASE_DEF = 8;
    localparam int unsigned MAX_TEXT_DEF   = 65536;

    // Saturation limits of the reported values
    localparam logic [INDEX_W-1:0] INDEX_SAT = '1;
    localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PHRASE_BYTES  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHRASE_LENGTH = 1'd1;

    // Phrase as seen by every cell
    typedef struct packed {
        logic [PHRASE_W-1:0] phrase;
        logic [LEN_W-1:0]    length;
    } cell_cfg_t;

    // Per-transaction control broadcast along the cell row
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/ssc_stream_if.sv =====
// Valid/ready channel interfaces for text bytes and search results.
// Depends on ssc_pkg for field widths.
`default_nettype none

interface ssc_text_if;
    logic                             valid;
    logic                             ready;
    logic [ssc_pkg::BYTE_W-1:0]       text_byte;
    logic                             last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface ssc_result_if;
    logic                             valid;
    logic                             ready;
    logic                             found;
    logic [ssc_pkg::INDEX_W-1:0]      first_index;
    logic [ssc_pkg::COUNT_W-1:0]      match_count;
    logic                             overflow;

    modport source (output valid, output found, output first_index, output match_count,
                    output overflow, input ready);
    modport sink   (input valid, input found, input first_index, input match_count,
                    input overflow, output ready);
endinterface

`default_nettype wire

// ===== src/ssc_cell.sv =====
// One window cell: holds one text byte and its valid bit, compares the byte it
// is about to take with its phrase byte. Depends on ssc_pkg.
`default_nettype none

module ssc_cell #(
    parameter int unsigned INDEX = 0
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ssc_pkg::cell_ctrl_t        ctrl,
    input  wire ssc_pkg::cell_cfg_t         cfg,
    input  wire logic [ssc_pkg::BYTE_W-1:0] data_in,
    input  wire logic                       valid_in,
    output logic [ssc_pkg::BYTE_W-1:0]      data_out,
    output logic                            valid_out,
    output logic                            hit
);

    logic [ssc_pkg::BYTE_W-1:0] data_reg;
    logic                       valid_reg;
    logic                       valid_next;
    logic [ssc_pkg::LEN_W-1:0]  sel;
    logic                       active;
    logic [ssc_pkg::BYTE_W-1:0] want;

    // Phrase byte that must sit in this cell: window[k] pairs with byte len-1-k
    assign sel    = ssc_pkg::LEN_W'(cfg.length - ssc_pkg::LEN_W'(1)
                                    - ssc_pkg::LEN_W'(INDEX));
    assign active = ssc_pkg::LEN_W'(INDEX) < cfg.length;
    assign want   = cfg.phrase[{sel[ssc_pkg::SEL_W-1:0], 3'b000} +: ssc_pkg::BYTE_W];

    // Judge the value this cell will hold after the shift
    assign hit = !active || (valid_in && (data_in == want));

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = valid_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= data_in;
        end
    end

    assign data_out  = data_reg;
    assign valid_out = valid_reg;

endmodule

`default_nettype wire

// ===== src/substring_search_count.sv =====
// Streaming substring search with overlapping occurrence count.
// Throughput: one text byte per cycle unless a final byte meets an untaken
// result; the whole cell row compares in parallel, the counters update in the
// byte's own cycle, and the result is valid in the cycle after the final byte.
// Reset: clears the window, counters and result register; phrase resets to
// all zero bytes with length one. Depends on ssc_pkg, ssc_stream_if, ssc_cell.
`default_nettype none

module substring_search_count #(
    parameter int unsigned MAX_PHRASE = ssc_pkg::MAX_PHRASE_DEF,
    parameter int unsigned MAX_TEXT   = ssc_pkg::MAX_TEXT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ssc_pkg::CFG_DATA_W-1:0] cfg_data,
    ssc_text_if.sink                            text_in,
    ssc_result_if.source                        result_out
);

    // Position counter must reach MAX_TEXT itself; the start index is worked
    // out wide enough to compare against the 16-bit saturation limit.
    localparam int unsigned POS_W  = $clog2(MAX_TEXT + 1);
    localparam int unsigned CALC_W = (POS_W > ssc_pkg::COUNT_W) ? POS_W : ssc_pkg::COUNT_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ssc_pkg::PHRASE_W-1:0] phrase_reg;
    logic [ssc_pkg::PHRASE_W-1:0] phrase_next;
    logic [ssc_pkg::LEN_W-1:0]    len_reg;
    logic [ssc_pkg::LEN_W-1:0]    len_next;
    logic [ssc_pkg::LEN_W-1:0]    len_raw;

    assign len_raw = cfg_data[ssc_pkg::LEN_W-1:0];

    // Clamp the length on the way in: zero acts as one, anything above the
    // cell count acts as the full row.
    always_comb
    begin
        phrase_next = phrase_reg;
        len_next    = len_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ssc_pkg::REG_PHRASE_BYTES:
                begin
                    phrase_next = cfg_data;
                end
                ssc_pkg::REG_PHRASE_LENGTH:
                begin
                    if (len_raw == '0)
                    begin
                        len_next = ssc_pkg::LEN_W'(1);
                    end
                    else if (len_raw > ssc_pkg::LEN_W'(MAX_PHRASE))
                    begin
                        len_next = ssc_pkg::LEN_W'(MAX_PHRASE);
                    end
                    else
                    begin
                        len_next = len_raw;
                    end
                end
                default:
                begin
                    phrase_next = phrase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phrase_reg <= '0;
            len_reg    <= ssc_pkg::LEN_W'(1);
        end
        else
        begin
            phrase_reg <= phrase_next;
            len_reg    <= len_next;
        end
    end

    // ------------------------------------------------------------------
    // Input handshake
    // ------------------------------------------------------------------
    logic out_valid_reg;
    logic in_accept;
    logic searched;

    // Only a final byte needs room in the result register; ordinary bytes
    // flow on while a result waits.
    assign text_in.ready = !out_valid_reg || result_out.ready || !text_in.last_byte;
    assign in_accept     = text_in.valid && text_in.ready;

    // ------------------------------------------------------------------
    // Cell row: the window shifts one cell per searched byte
    // ------------------------------------------------------------------
    ssc_pkg::cell_cfg_t  cell_cfg;
    ssc_pkg::cell_ctrl_t cell_ctrl;
    logic [ssc_pkg::BYTE_W-1:0] chain_data [MAX_PHRASE+1];
    logic [MAX_PHRASE:0]        chain_valid;
    logic [MAX_PHRASE-1:0]      hit_vec;
    logic [MAX_PHRASE-1:0]      valid_vec;
    logic                       match;

    assign cell_cfg.phrase  = phrase_reg;
    assign cell_cfg.length  = len_reg;
    assign cell_ctrl.shift  = in_accept && searched;
    assign cell_ctrl.clear  = in_accept && text_in.last_byte;

    // Cell zero takes the incoming byte
    assign chain_data[0]  = text_in.text_byte;
    assign chain_valid[0] = 1'b1;

    genvar k;
    generate
        for (k = 0; k < MAX_PHRASE; k++)
        begin : g_cell
            ssc_cell #(
                .INDEX (k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (cell_ctrl),
                .cfg       (cell_cfg),
                .data_in   (chain_data[k]),
                .valid_in  (chain_valid[k]),
                .data_out  (chain_data[k+1]),
                .valid_out (chain_valid[k+1]),
                .hit       (hit_vec[k])
            );
        end
    endgenerate

    assign valid_vec = chain_valid[MAX_PHRASE:1];
    assign match     = searched && (&hit_vec);

    // ------------------------------------------------------------------
    // Position, count and first-occurrence tracking
    // ------------------------------------------------------------------
    logic [POS_W-1:0]             position_reg;
    logic [POS_W-1:0]             position_next;
    logic [POS_W-1:0]             position_inc;
    logic [ssc_pkg::COUNT_W-1:0]  count_reg;
    logic [ssc_pkg::COUNT_W-1:0]  count_next;
    logic                         seen_reg;
    logic                         seen_next;
    logic [ssc_pkg::INDEX_W-1:0]  first_reg;
    logic [ssc_pkg::INDEX_W-1:0]  first_next;
    logic                         ovf_reg;
    logic                         ovf_next;
    logic [CALC_W-1:0]            start_wide;

    // Bytes past the text limit are dropped from the search
    assign searched     = !ovf_reg && (position_reg < POS_W'(MAX_TEXT));
    assign position_inc = position_reg + POS_W'(1);
    assign start_wide   = CALC_W'(position_inc) - CALC_W'(len_reg);

    always_comb
    begin
        position_next = position_reg;
        count_next    = count_reg;
        seen_next     = seen_reg;
        first_next    = first_reg;
        ovf_next      = ovf_reg;
        if (!searched)
        begin
            ovf_next = 1'b1;
        end
        else
        begin
            position_next = position_inc;
            if (match)
            begin
                if (count_reg != ssc_pkg::COUNT_SAT)
                begin
                    count_next = count_reg + ssc_pkg::COUNT_W'(1);
                end
                if (!seen_reg)
                begin
                    seen_next = 1'b1;
                    if (start_wide > CALC_W'(ssc_pkg::INDEX_SAT))
                    begin
                        first_next = ssc_pkg::INDEX_SAT;
                    end
                    else
                    begin
                        first_next = start_wide[ssc_pkg::INDEX_W-1:0];
                    end
                end
            end
        end
    end

    // Clear all text state after the final byte so the next text starts fresh
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            count_reg    <= '0;
            seen_reg     <= 1'b0;
            first_reg    <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (in_accept)
        begin
            if (text_in.last_byte)
            begin
                position_reg <= '0;
                count_reg    <= '0;
                seen_reg     <= 1'b0;
                first_reg    <= '0;
                ovf_reg      <= 1'b0;
            end
            else
            begin
                position_reg <= position_next;
                count_reg    <= count_next;
                seen_reg     <= seen_next;
                first_reg    <= first_next;
                ovf_reg      <= ovf_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on the final byte, hold until taken
    // ------------------------------------------------------------------
    logic                         out_valid_next;
    logic                         found_reg;
    logic [ssc_pkg::INDEX_W-1:0]  index_reg;
    logic [ssc_pkg::COUNT_W-1:0]  mcount_reg;
    logic                         oflow_reg;
    logic                         load_result;

    assign load_result = in_accept && text_in.last_byte;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_result)
        begin
            found_reg  <= seen_next;
            index_reg  <= seen_next ? first_next : '0;
            mcount_reg <= count_next;
            oflow_reg  <= ovf_next;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.found       = found_reg;
    assign result_out.first_index = index_reg;
    assign result_out.match_count = mcount_reg;
    assign result_out.overflow    = oflow_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Window valid bits fill from cell zero without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + MAX_PHRASE'(1)) & valid_vec) == '0)
        else $error("window valid bits not contiguous");

    // Position never passes the text limit
    assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= POS_W'(MAX_TEXT))
        else $error("position beyond text limit");

    // A final byte always yields a result and empties the text state
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && text_in.last_byte) |=>
            (out_valid_reg && (position_reg == '0) && (valid_vec == '0) && !seen_reg))
        else $error("final byte did not produce result or clear state");

    // Active length always lies within the cell row
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg != '0) && (len_reg <= ssc_pkg::LEN_W'(MAX_PHRASE)))
        else $error("phrase length out of range");

    // A recorded first occurrence implies a non-zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg |-> (count_reg != '0))
        else $error("first occurrence recorded without a count");

endmodule

`default_nettype wire
